>>> src/spss_pkg.sv
// shared types, codes and crc helpers for the storage power setpoint stepper
`timescale 1ns / 1ps

package spss_pkg;

    // converter mode codes
    localparam logic [1:0] PCS_CHARGE    = 2'd0;
    localparam logic [1:0] PCS_DISCHARGE = 2'd1;
    localparam logic [1:0] PCS_STANDBY   = 2'd2;
    localparam logic [1:0] PCS_OTHER     = 2'd3;

    // plan mode codes
    localparam logic [1:0] PLAN_CHARGE    = 2'd0;
    localparam logic [1:0] PLAN_DISCHARGE = 2'd1;
    localparam logic [1:0] PLAN_STANDBY   = 2'd2;
    localparam logic [1:0] PLAN_UNKNOWN   = 2'd3;

    // battery advice codes
    localparam logic [1:0] ADV_LOWER  = 2'd0;
    localparam logic [1:0] ADV_STABLE = 2'd1;
    localparam logic [1:0] ADV_RAISE  = 2'd2;
    localparam logic [1:0] ADV_NONE   = 2'd3;

    // command kinds
    localparam logic [1:0] ACT_POWER_OFF = 2'd0;
    localparam logic [1:0] ACT_POWER_ON  = 2'd1;
    localparam logic [1:0] ACT_SET_POWER = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_MAX    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCHARGE_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOC_CEILING   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOC_FLOOR     = 2'd3;
    localparam int unsigned CFG_DATA_W = 9;

    // configuration reset values
    localparam logic [8:0] CHARGE_MAX_RST    = 9'd500;
    localparam logic [8:0] DISCHARGE_MAX_RST = 9'd500;
    localparam logic [6:0] SOC_CEILING_RST   = 7'd100;
    localparam logic [6:0] SOC_FLOOR_RST     = 7'd0;

    // setpoint handling
    localparam int unsigned POWER_LIMIT_DEF = 500;
    localparam logic [15:0] POWER_STEP      = 16'd10;

    // modbus frame constants
    localparam logic [15:0] ADDR_ONOFF = 16'h04CC;
    localparam logic [15:0] ADDR_POWER = 16'h04C4;
    localparam logic [15:0] DATA_OFF   = 16'hAAAA;
    localparam logic [15:0] DATA_ON    = 16'h5555;
    localparam logic [7:0]  SLAVE_ID   = 8'h01;
    localparam logic [7:0]  FUNC_WRITE = 8'h06;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam int unsigned CRC_BYTES  = 4;

    // input word, first field in the highest bits
    typedef struct packed {
        logic [6:0] plan_soc;
        logic [8:0] plan_power;
        logic [1:0] plan_mode;
        logic [8:0] setting_power;
        logic [1:0] pcs_mode;
        logic       pcs_powered;
        logic [1:0] discharge_advice;
        logic [1:0] charge_advice;
        logic [6:0] battery_soc;
        logic       allow_discharge;
        logic       allow_charge;
        logic       allow_running;
    } spss_in_t;

    localparam int unsigned IN_BITS   = $bits(spss_in_t);
    localparam int unsigned IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // command before the crc is added
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] reg_addr;
        logic [15:0] reg_data;
    } spss_cmd_t;

    // result word, first field in the highest bits
    typedef struct packed {
        logic [15:0] frame_crc;
        logic [15:0] reg_data;
        logic [15:0] reg_addr;
    } spss_frame_t;

    localparam int unsigned OUT_TDATA_W = $bits(spss_frame_t);

    // one byte of modbus crc-16, reflected
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // crc after the fixed slave and function bytes
    localparam logic [15:0] CRC_SEED = crc_byte(crc_byte(CRC_INIT, SLAVE_ID), FUNC_WRITE);

endpackage

>>> src/spss_decide.sv
// protection registers and two-stage command decision
`timescale 1ns / 1ps

module spss_decide
    import spss_pkg::*;
#(
    parameter int unsigned POWER_LIMIT = POWER_LIMIT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  spss_in_t              in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output spss_cmd_t             out_cmd
);

    localparam logic [15:0] LIMIT = 16'(POWER_LIMIT);

    typedef struct packed {
        logic        run;
        logic        powered;
        logic [1:0]  mode;
        logic [1:0]  pmode;
        logic        allowed;
        logic [1:0]  advice;
        logic [6:0]  bsoc;
        logic [8:0]  sp;
        logic [8:0]  pp;
        logic [6:0]  st;
        logic [15:0] sp_hold;
        logic [15:0] sp_low;
        logic [15:0] sp_raise;
    } stage_a_t;

    logic [8:0] charge_max_reg;
    logic [8:0] discharge_max_reg;
    logic [6:0] soc_ceiling_reg;
    logic [6:0] soc_floor_reg;

    logic       a_valid_reg, a_valid_next;
    stage_a_t   a_reg, a_next;
    logic       b_valid_reg, b_valid_next;
    spss_cmd_t  b_reg, b_next;
    logic       a_ready, b_ready;

    logic       emit;
    logic       charging;
    logic [15:0] power;
    logic       plan_same;
    logic       soc_ok;

    function automatic logic [15:0] sat_power(input logic [15:0] p);
        return (p > LIMIT) ? LIMIT : p;
    endfunction

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            charge_max_reg    <= CHARGE_MAX_RST;
            discharge_max_reg <= DISCHARGE_MAX_RST;
            soc_ceiling_reg   <= SOC_CEILING_RST;
            soc_floor_reg     <= SOC_FLOOR_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CHARGE_MAX:    charge_max_reg    <= cfg_data[8:0];
                CFG_DISCHARGE_MAX: discharge_max_reg <= cfg_data[8:0];
                CFG_SOC_CEILING:   soc_ceiling_reg   <= cfg_data[6:0];
                CFG_SOC_FLOOR:     soc_floor_reg     <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // stage ready chain
    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // stage a: clip the plan and form the candidate setpoints
    always_comb begin
        logic        dis;
        logic [15:0] sp16;
        dis  = (in_item.pcs_mode == PCS_DISCHARGE);
        sp16 = {7'd0, in_item.setting_power};

        a_next.run     = in_item.allow_running;
        a_next.powered = in_item.pcs_powered;
        a_next.mode    = in_item.pcs_mode;
        a_next.pmode   = in_item.plan_mode;
        a_next.allowed = dis ? in_item.allow_discharge : in_item.allow_charge;
        a_next.advice  = dis ? in_item.discharge_advice : in_item.charge_advice;
        a_next.bsoc    = in_item.battery_soc;
        a_next.sp      = in_item.setting_power;
        if (dis) begin
            a_next.pp = (in_item.plan_power > discharge_max_reg) ? discharge_max_reg
                                                                 : in_item.plan_power;
            a_next.st = (in_item.plan_soc < soc_floor_reg) ? soc_floor_reg
                                                           : in_item.plan_soc;
        end else begin
            a_next.pp = (in_item.plan_power > charge_max_reg) ? charge_max_reg
                                                              : in_item.plan_power;
            a_next.st = (in_item.plan_soc > soc_ceiling_reg) ? soc_ceiling_reg
                                                             : in_item.plan_soc;
        end
        a_next.sp_hold  = sat_power(sp16);
        a_next.sp_low   = (sp16 > POWER_STEP) ? sat_power(sp16 - POWER_STEP) : 16'd0;
        a_next.sp_raise = sat_power(sp16 + POWER_STEP);
        a_valid_next    = a_ready ? in_valid : a_valid_reg;
    end

    // stage b: pick the action and the new setpoint
    assign plan_same = (a_reg.pmode == a_reg.mode);
    assign soc_ok    = (a_reg.st > a_reg.bsoc);

    always_comb begin
        emit     = 1'b0;
        charging = (a_reg.mode == PCS_CHARGE);
        power    = a_reg.sp_low;
        b_next   = b_reg;
        b_next.action   = ACT_SET_POWER;
        b_next.reg_addr = ADDR_POWER;
        if (!a_reg.run) begin
            emit            = a_reg.powered;
            b_next.action   = ACT_POWER_OFF;
            b_next.reg_addr = ADDR_ONOFF;
        end else if (!a_reg.powered) begin
            emit            = 1'b1;
            b_next.action   = ACT_POWER_ON;
            b_next.reg_addr = ADDR_ONOFF;
        end else if (a_reg.mode == PCS_CHARGE || a_reg.mode == PCS_DISCHARGE) begin
            emit = 1'b1;
            if (!a_reg.allowed) begin
                power = a_reg.sp_low;
            end else begin
                case (a_reg.advice)
                    ADV_LOWER: power = a_reg.sp_low;
                    ADV_STABLE: begin
                        if (plan_same && ({7'd0, a_reg.pp} >= {7'd0, a_reg.sp}) && soc_ok)
                            power = a_reg.sp_hold;
                    end
                    ADV_RAISE: begin
                        if (plan_same && soc_ok && (a_reg.pp > a_reg.sp))
                            power = a_reg.sp_raise;
                        else if (plan_same && soc_ok && (a_reg.pp == a_reg.sp))
                            power = a_reg.sp_hold;
                    end
                    default: emit = 1'b0;
                endcase
            end
        end else if (a_reg.mode == PCS_STANDBY) begin
            power = a_reg.sp_raise;
            case (a_reg.pmode)
                PLAN_CHARGE: begin
                    emit     = 1'b1;
                    charging = 1'b1;
                end
                PLAN_DISCHARGE: begin
                    emit     = 1'b1;
                    charging = 1'b0;
                end
                default: emit = 1'b0;
            endcase
        end

        // data word for the chosen action
        case (b_next.action)
            ACT_POWER_OFF: b_next.reg_data = DATA_OFF;
            ACT_POWER_ON:  b_next.reg_data = DATA_ON;
            default:       b_next.reg_data = charging ? (16'd0 - power) : power;
        endcase

        b_valid_next = b_ready ? (a_valid_reg && emit) : b_valid_reg;
        if (!b_ready) b_next = b_reg;
    end

    // pipeline registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready) a_reg <= a_next;
        if (b_ready) b_reg <= b_next;
    end

    assign out_valid = b_valid_reg;
    assign out_cmd   = b_reg;

endmodule

>>> src/spss_crc.sv
// modbus crc pipeline, one frame byte per stage
`timescale 1ns / 1ps

module spss_crc
    import spss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  spss_cmd_t   in_cmd,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  out_action,
    output spss_frame_t out_frame
);

    logic      valid_reg [CRC_BYTES];
    spss_cmd_t cmd_reg   [CRC_BYTES];
    logic [15:0] crc_reg [CRC_BYTES];
    logic      stage_ready [CRC_BYTES];

    // ready chain from the output back
    always_comb begin
        for (int k = CRC_BYTES - 1; k >= 0; k--) begin
            if (k == CRC_BYTES - 1)
                stage_ready[k] = !valid_reg[k] || out_ready;
            else
                stage_ready[k] = !valid_reg[k] || stage_ready[k + 1];
        end
    end

    assign in_ready = stage_ready[0];

    // one stage per address and data byte, high byte first
    for (genvar g = 0; g < CRC_BYTES; g++) begin : g_stage
        logic        prev_valid;
        spss_cmd_t   prev_cmd;
        logic [15:0] prev_crc;
        logic [31:0] word;

        if (g == 0) begin : g_first
            assign prev_valid = in_valid;
            assign prev_cmd   = in_cmd;
            assign prev_crc   = CRC_SEED;
        end else begin : g_rest
            assign prev_valid = valid_reg[g - 1];
            assign prev_cmd   = cmd_reg[g - 1];
            assign prev_crc   = crc_reg[g - 1];
        end

        assign word = {prev_cmd.reg_addr, prev_cmd.reg_data};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[g] <= 1'b0;
            end else if (stage_ready[g]) begin
                valid_reg[g] <= prev_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_ready[g]) begin
                cmd_reg[g] <= prev_cmd;
                crc_reg[g] <= crc_byte(prev_crc, word[(CRC_BYTES - 1 - g) * 8 +: 8]);
            end
        end
    end

    assign out_valid           = valid_reg[CRC_BYTES - 1];
    assign out_action          = cmd_reg[CRC_BYTES - 1].action;
    assign out_frame.reg_addr  = cmd_reg[CRC_BYTES - 1].reg_addr;
    assign out_frame.reg_data  = cmd_reg[CRC_BYTES - 1].reg_data;
    assign out_frame.frame_crc = crc_reg[CRC_BYTES - 1];

endmodule

>>> src/storage_power_setpoint_stepper_top.sv
// top level of the storage power setpoint stepper
//
//  channel  dir  word contents (lowest bits first)
//  s_       in   allow_running, allow_charge, allow_discharge, battery_soc, charge_advice,
//                discharge_advice, pcs_powered, pcs_mode, setting_power, plan_mode,
//                plan_power, plan_soc
//  m_       out  tdata: reg_addr, reg_data, frame_crc; tuser: action
//  cfg_     in   0 charge_power_max, 1 discharge_power_max, 2 soc_ceiling, 3 soc_floor
//
// one word accepted per cycle unless a stalled output holds the pipeline; a command leaves
// after its tick passes two decision stages, then four crc stages, one frame byte each
// ticks that cause no command are dropped after the decision stage
// a stalled output holds the pipeline stage by stage; bubbles still fill in behind it
// reset (aresetn low at a clock edge) empties the pipeline and restores the limits
`timescale 1ns / 1ps

module storage_power_setpoint_stepper_top
    import spss_pkg::*;
#(
    parameter int unsigned POWER_LIMIT = POWER_LIMIT_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write port
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input ticks
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // allow_running, allow_charge, allow_discharge, battery_soc, charge_advice,
    // discharge_advice, pcs_powered, pcs_mode, setting_power, plan_mode,
    // plan_power, plan_soc, zero fill
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // commands
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // reg_addr, reg_data, frame_crc
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // action
    output logic [1:0]             m_tuser
);

    spss_in_t    in_item;
    logic        cmd_valid;
    logic        cmd_ready;
    spss_cmd_t   cmd;
    spss_frame_t frame;

    assign in_item = spss_in_t'(s_tdata[IN_BITS-1:0]);

    // decision stages
    spss_decide #(
        .POWER_LIMIT (POWER_LIMIT)
    ) u_decide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (cmd_valid),
        .out_ready (cmd_ready),
        .out_cmd   (cmd)
    );

    // crc stages
    spss_crc u_crc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (cmd_valid),
        .in_ready   (cmd_ready),
        .in_cmd     (cmd),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_action (m_tuser),
        .out_frame  (frame)
    );

    assign m_tdata = frame;

`ifndef ASSERT_OFF
    // power commands go to the power register
    a_power_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ACT_SET_POWER) |-> (m_tdata[15:0] == ADDR_POWER))
        else $error("power command with wrong register address");

    // on and off commands carry the matching code
    a_onoff_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ACT_POWER_OFF || m_tuser == ACT_POWER_ON) |->
        (m_tdata[15:0] == ADDR_ONOFF) &&
        (m_tdata[31:16] == ((m_tuser == ACT_POWER_ON) ? DATA_ON : DATA_OFF)))
        else $error("on/off command with wrong address or data");

    // commanded setpoint magnitude never exceeds the limit
    a_power_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ACT_SET_POWER) |->
        (m_tdata[31:16] <= 16'(POWER_LIMIT)) ||
        ((16'd0 - m_tdata[31:16]) <= 16'(POWER_LIMIT)))
        else $error("setpoint beyond power limit");

    // no action code beyond the defined three
    a_action_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ACT_POWER_OFF || m_tuser == ACT_POWER_ON ||
                      m_tuser == ACT_SET_POWER))
        else $error("undefined action code");

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");
`endif

endmodule

>>> bench/storage_power_setpoint_stepper_top_test.sv
// self-checking bench for the storage power setpoint stepper, random and directed ticks
`timescale 1ns / 1ps

module storage_power_setpoint_stepper_top_test;
    import spss_pkg::*;

    localparam int unsigned SETPOINT_CAP  = 500;
    localparam int unsigned SETPOINT_STEP = 10;
    localparam int unsigned DRAIN_CYCLES  = 20;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned PHASES        = 8;
    localparam int unsigned PHASE_TICKS   = 230;

    // one expected command word
    typedef struct {
        logic [1:0]  action;
        spss_frame_t frame;
    } command_t;

    // predicts the command each tick causes and checks the output against it
    class setpoint_scoreboard;
        int unsigned charge_max;
        int unsigned discharge_max;
        int unsigned soc_ceil;
        int unsigned soc_flr;
        int unsigned mismatches;
        command_t    pending_commands[$];

        function new();
            charge_max    = 500;
            discharge_max = 500;
            soc_ceil      = 100;
            soc_flr       = 0;
            mismatches    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_CHARGE_MAX:    charge_max    = v;
                CFG_DISCHARGE_MAX: discharge_max = v;
                CFG_SOC_CEILING:   soc_ceil      = v[6:0];
                CFG_SOC_FLOOR:     soc_flr       = v[6:0];
                default: ;
            endcase
        endfunction

        function int unsigned clamp(int unsigned p);
            return (p > SETPOINT_CAP) ? SETPOINT_CAP : p;
        endfunction

        function int unsigned step_down(int unsigned p);
            return (p > SETPOINT_STEP) ? clamp(p - SETPOINT_STEP) : 0;
        endfunction

        // new setpoint for one running direction, -1 when no command
        function int next_setpoint(bit allowed, logic [1:0] advice, bit plan_same,
                                   int unsigned pp, int unsigned soc_target,
                                   int unsigned bsoc, int unsigned sp);
            bit soc_ok;
            soc_ok = soc_target > bsoc;
            if (!allowed) return step_down(sp);
            case (advice)
                ADV_LOWER:  return step_down(sp);
                ADV_STABLE: begin
                    if (plan_same && pp >= sp && soc_ok) return clamp(sp);
                    return step_down(sp);
                end
                ADV_RAISE: begin
                    if (plan_same && soc_ok && pp > sp) return clamp(sp + SETPOINT_STEP);
                    if (plan_same && soc_ok && pp == sp) return clamp(sp);
                    return step_down(sp);
                end
                default: return -1;
            endcase
        endfunction

        // modbus crc-16 over slave, function, address and data bytes
        function logic [15:0] frame_crc(logic [15:0] addr, logic [15:0] data);
            logic [7:0]  bytes [6];
            logic [15:0] crc;
            bytes = '{SLAVE_ID, FUNC_WRITE, addr[15:8], addr[7:0], data[15:8], data[7:0]};
            crc = 16'hFFFF;
            foreach (bytes[i]) begin
                crc ^= {8'h00, bytes[i]};
                for (int k = 0; k < 8; k++)
                    crc = crc[0] ? ((crc >> 1) ^ 16'hA001) : (crc >> 1);
            end
            return crc;
        endfunction

        function void push_command(logic [1:0] action, logic [15:0] addr, logic [15:0] data);
            command_t c;
            c.action          = action;
            c.frame.reg_addr  = addr;
            c.frame.reg_data  = data;
            c.frame.frame_crc = frame_crc(addr, data);
            pending_commands = {pending_commands, c};
        endfunction

        function void predict_command(spss_in_t t);
            int          next;
            bit          charging;
            int unsigned pp;
            int unsigned st;
            logic [15:0] data;
            next     = -1;
            charging = 0;
            // shutdown and power-on take precedence
            if (!t.allow_running) begin
                if (t.pcs_powered) push_command(ACT_POWER_OFF, ADDR_ONOFF, DATA_OFF);
                return;
            end
            if (!t.pcs_powered) begin
                push_command(ACT_POWER_ON, ADDR_ONOFF, DATA_ON);
                return;
            end
            case (t.pcs_mode)
                PCS_CHARGE: begin
                    pp = (t.plan_power > charge_max) ? charge_max : t.plan_power;
                    st = (t.plan_soc > soc_ceil) ? soc_ceil : t.plan_soc;
                    next = next_setpoint(t.allow_charge, t.charge_advice,
                                         t.plan_mode == PLAN_CHARGE, pp, st,
                                         t.battery_soc, t.setting_power);
                    charging = 1;
                end
                PCS_DISCHARGE: begin
                    pp = (t.plan_power > discharge_max) ? discharge_max : t.plan_power;
                    st = (t.plan_soc < soc_flr) ? soc_flr : t.plan_soc;
                    next = next_setpoint(t.allow_discharge, t.discharge_advice,
                                         t.plan_mode == PLAN_DISCHARGE, pp, st,
                                         t.battery_soc, t.setting_power);
                end
                PCS_STANDBY: begin
                    if (t.plan_mode == PLAN_CHARGE) begin
                        next = clamp(t.setting_power + SETPOINT_STEP);
                        charging = 1;
                    end else if (t.plan_mode == PLAN_DISCHARGE) begin
                        next = clamp(t.setting_power + SETPOINT_STEP);
                    end
                end
                default: ;
            endcase
            if (next < 0) return;
            // charge power goes out negated
            data = next[15:0];
            if (charging) data = 16'(0) - data;
            push_command(ACT_SET_POWER, ADDR_POWER, data);
        endfunction

        task report(string what);
            $display("ERROR %0t: %s", $time, what);
            mismatches++;
        endtask

        task check_command(logic [OUT_TDATA_W-1:0] tdata, logic [1:0] tuser);
            command_t    exp_cmd;
            spss_frame_t got;
            got = tdata;
            if (pending_commands.size() == 0) begin
                report($sformatf("command with none pending: action %0d addr %h data %h",
                                 tuser, got.reg_addr, got.reg_data));
                return;
            end
            exp_cmd = pending_commands.pop_front();
            if (tuser !== exp_cmd.action)
                report($sformatf("action %0d, wanted %0d", tuser, exp_cmd.action));
            if (got.reg_addr !== exp_cmd.frame.reg_addr)
                report($sformatf("reg_addr %h, wanted %h", got.reg_addr,
                                 exp_cmd.frame.reg_addr));
            if (got.reg_data !== exp_cmd.frame.reg_data)
                report($sformatf("reg_data %h, wanted %h", got.reg_data,
                                 exp_cmd.frame.reg_data));
            if (got.frame_crc !== exp_cmd.frame.frame_crc)
                report($sformatf("frame_crc %h, wanted %h", got.frame_crc,
                                 exp_cmd.frame.frame_crc));
        endtask

        function int pending();
            return pending_commands.size();
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]             m_tuser;

    setpoint_scoreboard sb;
    int unsigned idle_cycles = 0;
    int unsigned stall_pct   = 0;
    int unsigned stall_left  = 0;
    int unsigned gap_pct     = 0;

    storage_power_setpoint_stepper_top #(
        .POWER_LIMIT(SETPOINT_CAP)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    // receiver backpressure: random stall runs
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 12);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor both channels, count cycles with no word moving
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.predict_command(spss_in_t'(s_tdata[IN_BITS-1:0]));
        if (aresetn && m_tvalid && m_tready)
            sb.check_command(m_tdata, m_tuser);
        if (aresetn && ((s_tvalid && s_tready) || (m_tvalid && m_tready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // watchdog
    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge aclk);
        $display("Mismatches found");
        $finish;
    end

    task send_tick(input spss_in_t t);
        s_tdata  <= IN_TDATA_W'(t);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task idle_gap(input int unsigned n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // wait for every pending command, then let dropped ticks flush
    task drain();
        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task write_limits(input logic [8:0] chg, input logic [8:0] dis,
                      input logic [8:0] ceil, input logic [8:0] flr);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_CHARGE_MAX;
        cfg_data  <= chg;
        @(posedge aclk);
        cfg_index <= CFG_DISCHARGE_MAX;
        cfg_data  <= dis;
        @(posedge aclk);
        cfg_index <= CFG_SOC_CEILING;
        cfg_data  <= ceil;
        @(posedge aclk);
        cfg_index <= CFG_SOC_FLOOR;
        cfg_data  <= flr;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(CFG_CHARGE_MAX, chg);
        sb.write_reg(CFG_DISCHARGE_MAX, dis);
        sb.write_reg(CFG_SOC_CEILING, ceil);
        sb.write_reg(CFG_SOC_FLOOR, flr);
    endtask

    // directed tick, same advice and permission for both directions
    function automatic spss_in_t make_tick(bit run, bit pwr, logic [1:0] mode,
                                           logic [1:0] pmode, logic [1:0] adv, bit allow,
                                           int sp, int pp, int psoc, int bsoc);
        spss_in_t t;
        t.allow_running    = run;
        t.allow_charge     = allow;
        t.allow_discharge  = allow;
        t.battery_soc      = 7'(bsoc);
        t.charge_advice    = adv;
        t.discharge_advice = adv;
        t.pcs_powered      = pwr;
        t.pcs_mode         = mode;
        t.setting_power    = 9'(sp);
        t.plan_mode        = pmode;
        t.plan_power       = 9'(pp);
        t.plan_soc         = 7'(psoc);
        return t;
    endfunction

    // mostly running ticks with plan and setpoint near each other, some raw noise
    function automatic spss_in_t random_tick();
        spss_in_t    t;
        logic [63:0] raw;
        int unsigned pick;
        raw  = {$urandom(), $urandom()};
        t    = raw[IN_BITS-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 12) return t;
        t.allow_running   = $urandom_range(0, 99) < 96;
        t.pcs_powered     = $urandom_range(0, 99) < 95;
        t.allow_charge    = $urandom_range(0, 99) < 90;
        t.allow_discharge = $urandom_range(0, 99) < 90;
        pick = $urandom_range(0, 99);
        t.pcs_mode = (pick < 40) ? PCS_CHARGE : (pick < 80) ? PCS_DISCHARGE :
                     (pick < 95) ? PCS_STANDBY : PCS_OTHER;
        if ($urandom_range(0, 99) < 70) begin
            if (t.pcs_mode == PCS_CHARGE)
                t.plan_mode = PLAN_CHARGE;
            else if (t.pcs_mode == PCS_DISCHARGE)
                t.plan_mode = PLAN_DISCHARGE;
        end
        if ($urandom_range(0, 99) < 20) t.setting_power = 9'($urandom_range(0, 20));
        pick = $urandom_range(0, 2);
        if (pick == 0)
            t.plan_power = t.setting_power;
        else if (pick == 1)
            t.plan_power = (t.setting_power > 470) ? 9'd511 :
                           t.setting_power + 9'($urandom_range(1, 40));
        if ($urandom_range(0, 1) == 0)
            t.plan_soc = (t.battery_soc > 97) ? 7'd127 :
                         t.battery_soc + 7'($urandom_range(1, 30));
        return t;
    endfunction

    initial begin
        int unsigned burst_left;
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        write_limits(9'd500, 9'd500, 9'd100, 9'd0);

        // directed ticks under the reset limits
        send_tick(make_tick(0, 1, PCS_CHARGE, PLAN_CHARGE, ADV_RAISE, 1, 100, 200, 80, 50));
        send_tick(make_tick(0, 0, PCS_CHARGE, PLAN_CHARGE, ADV_RAISE, 1, 100, 200, 80, 50));
        send_tick(make_tick(1, 0, PCS_CHARGE, PLAN_CHARGE, ADV_RAISE, 1, 100, 200, 80, 50));
        send_tick(make_tick(1, 1, PCS_OTHER, PLAN_CHARGE, ADV_RAISE, 1, 100, 200, 80, 50));
        send_tick(make_tick(1, 1, PCS_STANDBY, PLAN_CHARGE, ADV_NONE, 0, 0, 0, 0, 0));
        send_tick(make_tick(1, 1, PCS_STANDBY, PLAN_DISCHARGE, ADV_NONE, 0, 495, 0, 0, 0));
        send_tick(make_tick(1, 1, PCS_STANDBY, PLAN_STANDBY, ADV_RAISE, 1, 511, 0, 0, 0));
        send_tick(make_tick(1, 1, PCS_STANDBY, PLAN_UNKNOWN, ADV_RAISE, 1, 511, 0, 0, 0));
        // advice none while running with permission
        send_tick(make_tick(1, 1, PCS_CHARGE, PLAN_CHARGE, ADV_NONE, 1, 200, 300, 90, 10));
        send_tick(make_tick(1, 1, PCS_DISCHARGE, PLAN_DISCHARGE, ADV_NONE, 1, 200, 300, 90, 10));
        // permission withdrawn, floor at zero and saturation on the way down
        send_tick(make_tick(1, 1, PCS_CHARGE, PLAN_CHARGE, ADV_RAISE, 0, 5, 300, 90, 10));
        send_tick(make_tick(1, 1, PCS_DISCHARGE, PLAN_DISCHARGE, ADV_STABLE, 0, 511, 300, 90, 10));
        // charging advice paths
        send_tick(make_tick(1, 1, PCS_CHARGE, PLAN_CHARGE, ADV_LOWER, 1, 100, 300, 90, 10));
        send_tick(make_tick(1, 1, PCS_CHARGE, PLAN_CHARGE, ADV_STABLE, 1, 200, 200, 80, 50));
        send_tick(make_tick(1, 1, PCS_CHARGE, PLAN_CHARGE, ADV_STABLE, 1, 200, 300, 50, 50));
        send_tick(make_tick(1, 1, PCS_CHARGE, PLAN_CHARGE, ADV_RAISE, 1, 200, 300, 80, 50));
        send_tick(make_tick(1, 1, PCS_CHARGE, PLAN_CHARGE, ADV_RAISE, 1, 200, 200, 80, 50));
        send_tick(make_tick(1, 1, PCS_CHARGE, PLAN_CHARGE, ADV_RAISE, 1, 200, 150, 80, 50));
        send_tick(make_tick(1, 1, PCS_CHARGE, PLAN_CHARGE, ADV_RAISE, 1, 495, 500, 100, 0));
        // discharging advice paths, plan power clipped by the limit
        send_tick(make_tick(1, 1, PCS_DISCHARGE, PLAN_DISCHARGE, ADV_RAISE, 1, 511, 511, 127, 0));
        send_tick(make_tick(1, 1, PCS_DISCHARGE, PLAN_DISCHARGE, ADV_STABLE, 1, 300, 400, 127, 127));
        send_tick(make_tick(1, 1, PCS_DISCHARGE, PLAN_CHARGE, ADV_STABLE, 1, 300, 400, 90, 10));
        send_tick(make_tick(1, 1, PCS_DISCHARGE, PLAN_DISCHARGE, ADV_RAISE, 1, 0, 500, 100, 0));
        // all field bits high, then all low
        send_tick('1);
        send_tick('0);
        drain();

        // random phases, each under its own limits and idling mix
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: ;
                1: write_limits(9'd0, 9'd0, 9'h180, 9'h180);
                2: write_limits(9'd511, 9'd511, 9'd127, 9'd127);
                3: write_limits(9'd500, 9'd500, 9'd100, 9'd0);
                default: write_limits(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                                      9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
            endcase
            gap_pct    = (ph == 0) ? 0 : $urandom_range(10, 70);
            stall_pct  = (ph == 0) ? 0 : $urandom_range(5, 60);
            burst_left = 0;
            for (int i = 0; i < PHASE_TICKS; i++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    if ($urandom_range(0, 99) < gap_pct) idle_gap($urandom_range(1, 10));
                end
                send_tick(random_tick());
                burst_left--;
            end
            drain();
        end

        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
